[design/grid_astar_path_search_core_defines.svh]
// Assertion macros used by the grid path search top level.
`ifndef GRID_ASTAR_PATH_SEARCH_CORE_DEFINES_SVH
`define GRID_ASTAR_PATH_SEARCH_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define GASTAR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
`define GASTAR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define GASTAR_ASSERT_IMP(lbl, ante, cons)
`define GASTAR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/gastar_pkg.sv]
// Types and constants of the grid path search core.
package gastar_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NOPATH   = 2'd1;
  localparam logic [1:0] STAT_REJECT   = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW = 2'd3;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [2:0] DIR_UP    = 3'd0;
  localparam logic [2:0] DIR_DOWN  = 3'd1;
  localparam logic [2:0] DIR_RIGHT = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_SELF  = 3'd4;

  localparam logic [2:0] CODE_FREE    = 3'd0;
  localparam logic [2:0] CODE_BLOCKED = 3'd1;
  localparam logic [2:0] CODE_START   = 3'd2;
  localparam logic [2:0] CODE_GOAL    = 3'd3;
  localparam logic [2:0] CODE_PATH    = 3'd4;

  localparam int COORD_W = 7;
  localparam int DIM_W   = 8;
  localparam int COST_W  = 25;
  localparam int STEPS_W = 15;
  localparam int SQRT_STEPS = 18;

  localparam logic [COST_W-1:0]  COST_INF  = 25'h1FFFFFF;
  localparam logic [COST_W-1:0]  COST_MAXF = 25'h1FFFFFE;
  localparam logic [STEPS_W-1:0] STEPS_MAX = 15'd32767;

  typedef struct packed {
    logic [COST_W-1:0]  f;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } key_t;

  typedef struct packed {
    logic               closed;
    logic [2:0]         dir;
    logic [STEPS_W-1:0] steps;
    logic [COST_W-1:0]  cost;
  } info_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_CHK,
    S_WIPE,
    S_SEED,
    S_POP_RD,
    S_POP_GET,
    S_SD_ISSUE,
    S_SD_CMP,
    S_SD_END,
    S_CUR_GET,
    S_NB,
    S_NB_GET,
    S_SQ1,
    S_SQ2,
    S_SQRT,
    S_COST,
    S_SU_ISSUE,
    S_SU_CMP,
    S_MARK_RD,
    S_MARK_GET,
    S_FIN_SRC,
    S_FIN_DST
  } fsm_t;

endpackage

[design/gastar_ram.sv]
// Generic RAM with one write port and two registered read ports.
module gastar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

[design/grid_astar_path_search_core.sv]
// Top level of the grid A* path search core: sequencer, grid, cell state and open heap.
//
// A result waits in an output register and no new transaction is taken until it has
// been delivered. A run item does the endpoint checks, a clearing sweep of the cell state
// memory, and then per expansion a heap pop with sift-down and one probe per neighbor.
// Each neighbor that is neither closed nor blocked goes through the squared distance,
// the bit-serial square root and the cost compare, and when its cost improves through a
// heap push with sift-up. The open heap and cell state memories each have one write port.
// On path success the path is walked back cell by cell and marked. After reset a clearing
// pass writes every grid cell free, and no item is taken until it ends; configuration
// writes are taken in every state.
`include "grid_astar_path_search_core_defines.svh"

module grid_astar_path_search_core #(
  parameter int GRID_SIDE  = 128,
  parameter int OPEN_DEPTH = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // row[6:0], col[13:7], cell_code[15:14], dst_row[22:16], dst_col[29:23], zero pad
  input  logic [31:0] s_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_code[2:0], status[4:3], zero pad
  output logic [7:0]  m_tdata,
  input  logic        cfg_wen,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  localparam int CELLS   = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W  = $clog2(CELLS);
  localparam int HEAP_AW = $clog2(OPEN_DEPTH);
  localparam int CNT_W   = $clog2(OPEN_DEPTH + 1);
  localparam int WALK_W  = $clog2(CELLS + 2);
  localparam int DIM_LIM = GRID_SIDE < 128 ? GRID_SIDE : 128;
  localparam int INFO_W  = $bits(gastar_pkg::info_t);
  localparam int KEY_W   = $bits(gastar_pkg::key_t);

  function automatic logic [CELL_W-1:0] cell_of(input logic [6:0] r, input logic [6:0] c);
    cell_of = CELL_W'(32'(r) * GRID_SIDE + 32'(c));
  endfunction

  function automatic logic [7:0] clamp_dim(input logic [7:0] v);
    logic [7:0] lim;
    lim = 8'(DIM_LIM);
    if (v == 8'd0) begin
      clamp_dim = 8'd1;
    end else if (v > lim) begin
      clamp_dim = lim;
    end else begin
      clamp_dim = v;
    end
  endfunction

  gastar_pkg::fsm_t state, state_next;
  logic              res_valid, res_valid_next;
  logic [2:0]        res_code, res_code_next;
  logic [1:0]        res_stat, res_stat_next;
  logic [7:0]        grid_rows, grid_cols;
  logic [CELL_W-1:0] sweep, sweep_next;
  logic [6:0]        src_r, src_r_next, src_c, src_c_next;
  logic [6:0]        dst_r, dst_r_next, dst_c, dst_c_next;
  logic [6:0]        cur_r, cur_r_next, cur_c, cur_c_next;
  logic [6:0]        nb_r, nb_r_next, nb_c, nb_c_next;
  logic [6:0]        walk_r, walk_r_next, walk_c, walk_c_next;
  logic [WALK_W-1:0] walk_n, walk_n_next;
  logic [14:0]       g_cur, g_cur_next, ng, ng_next;
  logic [24:0]       nb_best, nb_best_next;
  logic [2:0]        dir, dir_next;
  logic [CNT_W-1:0]  heap_cnt, heap_cnt_next;
  logic [HEAP_AW-1:0] heap_i, heap_i_next;
  gastar_pkg::key_t  last_key, last_key_next, push_key, push_key_next;
  logic [14:0]       sq_acc, sq_acc_next;
  logic [35:0]       sq_x, sq_x_next;
  logic [20:0]       sq_rem, sq_rem_next;
  logic [17:0]       sq_res, sq_res_next;
  logic [4:0]        sq_cnt, sq_cnt_next;

  logic              grid_we;
  logic [CELL_W-1:0] grid_wa, grid_ra, grid_rb;
  logic [2:0]        grid_wd, grid_qa, grid_qb;
  logic              info_we;
  logic [CELL_W-1:0] info_wa, info_ra;
  gastar_pkg::info_t info_wd, info_q;
  logic              heap_we;
  logic [HEAP_AW-1:0] heap_wa, heap_ra, heap_rb;
  gastar_pkg::key_t  heap_wd, heap_qa, heap_qb;

  logic [6:0]  in_row, in_col, in_drow, in_dcol;
  logic [1:0]  in_code;
  logic        accept;
  logic        in_ok, run_ok;
  logic        nb_ok;
  logic [6:0]  nr, nc;
  logic [7:0]  nr8, nc8;
  logic [6:0]  ddr, ddc, mul_in;
  logic [13:0] mul_out;
  logic [20:0] rem_sh, trial;
  logic [25:0] nf_sum;
  logic [24:0] nf;
  logic [HEAP_AW+1:0] l_ext, l1_ext, cnt_ext;
  logic        pick_r;
  gastar_pkg::key_t val_s;
  logic [HEAP_AW-1:0] heap_p;

  gastar_ram #(.WIDTH(3), .DEPTH(CELLS)) u_grid (
    .clk(clk), .wr_en(grid_we), .wr_addr(grid_wa), .wr_data(grid_wd),
    .rd_addr_a(grid_ra), .rd_data_a(grid_qa), .rd_addr_b(grid_rb), .rd_data_b(grid_qb)
  );

  gastar_ram #(.WIDTH(INFO_W), .DEPTH(CELLS)) u_info (
    .clk(clk), .wr_en(info_we), .wr_addr(info_wa), .wr_data(info_wd),
    .rd_addr_a(info_ra), .rd_data_a(info_q), .rd_addr_b(info_ra), .rd_data_b()
  );

  gastar_ram #(.WIDTH(KEY_W), .DEPTH(OPEN_DEPTH)) u_heap (
    .clk(clk), .wr_en(heap_we), .wr_addr(heap_wa), .wr_data(heap_wd),
    .rd_addr_a(heap_ra), .rd_data_a(heap_qa), .rd_addr_b(heap_rb), .rd_data_b(heap_qb)
  );

  assign in_row  = s_tdata[6:0];
  assign in_col  = s_tdata[13:7];
  assign in_code = s_tdata[15:14];
  assign in_drow = s_tdata[22:16];
  assign in_dcol = s_tdata[29:23];

  assign s_tready = (state == gastar_pkg::S_IDLE) && !res_valid;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = res_valid;
  assign m_tdata  = {3'b000, res_stat, res_code};

  assign in_ok  = ({1'b0, in_row} < grid_rows) && ({1'b0, in_col} < grid_cols);
  assign run_ok = in_ok && ({1'b0, in_drow} < grid_rows) && ({1'b0, in_dcol} < grid_cols);

  always_comb begin
    nr8 = {1'b0, cur_r};
    nc8 = {1'b0, cur_c};
    nb_ok = 1'b0;
    case (dir)
      gastar_pkg::DIR_UP: begin
        nb_ok = cur_r != 7'd0;
        nr8 = {1'b0, cur_r} - 8'd1;
      end
      gastar_pkg::DIR_DOWN: begin
        nr8 = {1'b0, cur_r} + 8'd1;
        nb_ok = nr8 < grid_rows;
      end
      gastar_pkg::DIR_RIGHT: begin
        nc8 = {1'b0, cur_c} + 8'd1;
        nb_ok = nc8 < grid_cols;
      end
      gastar_pkg::DIR_LEFT: begin
        nb_ok = cur_c != 7'd0;
        nc8 = {1'b0, cur_c} - 8'd1;
      end
      default: nb_ok = 1'b0;
    endcase
    nr = nr8[6:0];
    nc = nc8[6:0];
  end

  assign ddr     = nb_r > dst_r ? nb_r - dst_r : dst_r - nb_r;
  assign ddc     = nb_c > dst_c ? nb_c - dst_c : dst_c - nb_c;
  assign mul_in  = (state == gastar_pkg::S_SQ1) ? ddr : ddc;
  assign mul_out = mul_in * mul_in;
  assign rem_sh  = {sq_rem[18:0], sq_x[35:34]};
  assign trial   = {1'b0, sq_res, 2'b01};
  assign nf_sum  = {1'b0, ng, 10'd0} + {8'd0, sq_res};
  assign nf      = nf_sum > {1'b0, gastar_pkg::COST_MAXF} ? gastar_pkg::COST_MAXF
                                                           : nf_sum[24:0];
  assign l_ext   = {1'b0, heap_i, 1'b1};
  assign l1_ext  = l_ext + 1'b1;
  assign cnt_ext = (HEAP_AW + 2)'(heap_cnt);
  assign pick_r  = (l1_ext < cnt_ext) && (heap_qb < heap_qa);
  assign val_s   = pick_r ? heap_qb : heap_qa;
  assign heap_p  = HEAP_AW'((heap_i - 1'b1) >> 1);

  always_comb begin
    state_next     = state;
    res_valid_next = res_valid && !m_tready;
    res_code_next  = res_code;
    res_stat_next  = res_stat;
    sweep_next     = sweep;
    src_r_next     = src_r;
    src_c_next     = src_c;
    dst_r_next     = dst_r;
    dst_c_next     = dst_c;
    cur_r_next     = cur_r;
    cur_c_next     = cur_c;
    nb_r_next      = nb_r;
    nb_c_next      = nb_c;
    walk_r_next    = walk_r;
    walk_c_next    = walk_c;
    walk_n_next    = walk_n;
    g_cur_next     = g_cur;
    ng_next        = ng;
    nb_best_next   = nb_best;
    dir_next       = dir;
    heap_cnt_next  = heap_cnt;
    heap_i_next    = heap_i;
    last_key_next  = last_key;
    push_key_next  = push_key;
    sq_acc_next    = sq_acc;
    sq_x_next      = sq_x;
    sq_rem_next    = sq_rem;
    sq_res_next    = sq_res;
    sq_cnt_next    = sq_cnt;
    grid_we = 1'b0;
    grid_wa = '0;
    grid_wd = gastar_pkg::CODE_FREE;
    grid_ra = '0;
    grid_rb = '0;
    info_we = 1'b0;
    info_wa = '0;
    info_wd = '0;
    info_ra = '0;
    heap_we = 1'b0;
    heap_wa = '0;
    heap_wd = '0;
    heap_ra = '0;
    heap_rb = '0;

    unique case (state)
      gastar_pkg::S_CLEAR: begin
        grid_we = 1'b1;
        grid_wa = sweep;
        if (sweep == CELL_W'(CELLS - 1)) begin
          state_next = gastar_pkg::S_IDLE;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      gastar_pkg::S_IDLE: begin
        if (accept) begin
          res_code_next = gastar_pkg::CODE_FREE;
          res_stat_next = gastar_pkg::STAT_OK;
          case (s_tuser)
            gastar_pkg::OP_WRITE: begin
              res_valid_next = 1'b1;
              if (in_ok) begin
                grid_we = 1'b1;
                grid_wa = cell_of(in_row, in_col);
                grid_wd = {1'b0, in_code};
              end else begin
                res_stat_next = gastar_pkg::STAT_REJECT;
              end
            end
            gastar_pkg::OP_READ: begin
              if (in_ok) begin
                grid_ra = cell_of(in_row, in_col);
                state_next = gastar_pkg::S_RD;
              end else begin
                res_valid_next = 1'b1;
                res_stat_next = gastar_pkg::STAT_REJECT;
              end
            end
            gastar_pkg::OP_RUN: begin
              src_r_next = in_row;
              src_c_next = in_col;
              dst_r_next = in_drow;
              dst_c_next = in_dcol;
              if (run_ok) begin
                grid_ra = cell_of(in_row, in_col);
                grid_rb = cell_of(in_drow, in_dcol);
                state_next = gastar_pkg::S_CHK;
              end else begin
                res_valid_next = 1'b1;
                res_stat_next = gastar_pkg::STAT_REJECT;
              end
            end
            default: res_valid_next = 1'b1;
          endcase
        end
      end
      gastar_pkg::S_RD: begin
        res_valid_next = 1'b1;
        res_code_next = grid_qa;
        state_next = gastar_pkg::S_IDLE;
      end
      gastar_pkg::S_CHK: begin
        if (grid_qa == gastar_pkg::CODE_BLOCKED || grid_qb == gastar_pkg::CODE_BLOCKED ||
            (src_r == dst_r && src_c == dst_c)) begin
          res_valid_next = 1'b1;
          res_stat_next = gastar_pkg::STAT_REJECT;
          state_next = gastar_pkg::S_IDLE;
        end else begin
          sweep_next = '0;
          state_next = gastar_pkg::S_WIPE;
        end
      end
      gastar_pkg::S_WIPE: begin
        info_we = 1'b1;
        info_wa = sweep;
        info_wd = '{closed: 1'b0, dir: gastar_pkg::DIR_SELF, steps: '0,
                    cost: gastar_pkg::COST_INF};
        if (sweep == CELL_W'(CELLS - 1)) begin
          state_next = gastar_pkg::S_SEED;
        end else begin
          sweep_next = sweep + 1'b1;
        end
      end
      gastar_pkg::S_SEED: begin
        info_we = 1'b1;
        info_wa = cell_of(src_r, src_c);
        info_wd = '{closed: 1'b0, dir: gastar_pkg::DIR_SELF, steps: '0, cost: '0};
        heap_we = 1'b1;
        heap_wa = '0;
        heap_wd = '{f: '0, row: src_r, col: src_c};
        heap_cnt_next = CNT_W'(1);
        state_next = gastar_pkg::S_POP_RD;
      end
      gastar_pkg::S_POP_RD: begin
        if (heap_cnt == '0) begin
          res_valid_next = 1'b1;
          res_stat_next = gastar_pkg::STAT_NOPATH;
          state_next = gastar_pkg::S_IDLE;
        end else begin
          heap_ra = '0;
          heap_rb = HEAP_AW'(heap_cnt - 1'b1);
          heap_cnt_next = heap_cnt - 1'b1;
          state_next = gastar_pkg::S_POP_GET;
        end
      end
      gastar_pkg::S_POP_GET: begin
        cur_r_next = heap_qa.row;
        cur_c_next = heap_qa.col;
        last_key_next = heap_qb;
        heap_i_next = '0;
        state_next = gastar_pkg::S_SD_ISSUE;
      end
      gastar_pkg::S_SD_ISSUE: begin
        if (l_ext >= cnt_ext) begin
          state_next = gastar_pkg::S_SD_END;
        end else begin
          heap_ra = l_ext[HEAP_AW-1:0];
          heap_rb = l1_ext[HEAP_AW-1:0];
          state_next = gastar_pkg::S_SD_CMP;
        end
      end
      gastar_pkg::S_SD_CMP: begin
        if (val_s >= last_key) begin
          state_next = gastar_pkg::S_SD_END;
        end else begin
          heap_we = 1'b1;
          heap_wa = heap_i;
          heap_wd = val_s;
          heap_i_next = pick_r ? l1_ext[HEAP_AW-1:0] : l_ext[HEAP_AW-1:0];
          state_next = gastar_pkg::S_SD_ISSUE;
        end
      end
      gastar_pkg::S_SD_END: begin
        if (heap_cnt != '0) begin
          heap_we = 1'b1;
          heap_wa = heap_i;
          heap_wd = last_key;
        end
        info_ra = cell_of(cur_r, cur_c);
        state_next = gastar_pkg::S_CUR_GET;
      end
      gastar_pkg::S_CUR_GET: begin
        g_cur_next = info_q.steps;
        info_we = 1'b1;
        info_wa = cell_of(cur_r, cur_c);
        info_wd = info_q;
        info_wd.closed = 1'b1;
        dir_next = gastar_pkg::DIR_UP;
        state_next = gastar_pkg::S_NB;
      end
      gastar_pkg::S_NB: begin
        if (dir == gastar_pkg::DIR_SELF) begin
          state_next = gastar_pkg::S_POP_RD;
        end else if (!nb_ok) begin
          dir_next = dir + 1'b1;
        end else if (nr == dst_r && nc == dst_c) begin
          info_we = 1'b1;
          info_wa = cell_of(dst_r, dst_c);
          info_wd = '{closed: 1'b0, dir: dir, steps: '0, cost: '0};
          walk_r_next = dst_r;
          walk_c_next = dst_c;
          walk_n_next = '0;
          state_next = gastar_pkg::S_MARK_RD;
        end else begin
          grid_ra = cell_of(nr, nc);
          info_ra = cell_of(nr, nc);
          nb_r_next = nr;
          nb_c_next = nc;
          state_next = gastar_pkg::S_NB_GET;
        end
      end
      gastar_pkg::S_NB_GET: begin
        if (info_q.closed || grid_qa == gastar_pkg::CODE_BLOCKED) begin
          dir_next = dir + 1'b1;
          state_next = gastar_pkg::S_NB;
        end else begin
          ng_next = g_cur < gastar_pkg::STEPS_MAX ? g_cur + 1'b1 : gastar_pkg::STEPS_MAX;
          nb_best_next = info_q.cost;
          state_next = gastar_pkg::S_SQ1;
        end
      end
      gastar_pkg::S_SQ1: begin
        sq_acc_next = {1'b0, mul_out};
        state_next = gastar_pkg::S_SQ2;
      end
      gastar_pkg::S_SQ2: begin
        sq_x_next = {1'b0, sq_acc + {1'b0, mul_out}, 20'd0};
        sq_rem_next = '0;
        sq_res_next = '0;
        sq_cnt_next = '0;
        state_next = gastar_pkg::S_SQRT;
      end
      gastar_pkg::S_SQRT: begin
        if (rem_sh >= trial) begin
          sq_rem_next = rem_sh - trial;
          sq_res_next = {sq_res[16:0], 1'b1};
        end else begin
          sq_rem_next = rem_sh;
          sq_res_next = {sq_res[16:0], 1'b0};
        end
        sq_x_next = {sq_x[33:0], 2'b00};
        sq_cnt_next = sq_cnt + 1'b1;
        if (sq_cnt == 5'(gastar_pkg::SQRT_STEPS - 1)) begin
          state_next = gastar_pkg::S_COST;
        end
      end
      gastar_pkg::S_COST: begin
        if (nb_best > nf) begin
          info_we = 1'b1;
          info_wa = cell_of(nb_r, nb_c);
          info_wd = '{closed: 1'b0, dir: dir, steps: ng, cost: nf};
          if (heap_cnt >= CNT_W'(OPEN_DEPTH)) begin
            res_valid_next = 1'b1;
            res_stat_next = gastar_pkg::STAT_OVERFLOW;
            state_next = gastar_pkg::S_IDLE;
          end else begin
            heap_i_next = HEAP_AW'(heap_cnt);
            heap_cnt_next = heap_cnt + 1'b1;
            push_key_next = '{f: nf, row: nb_r, col: nb_c};
            state_next = gastar_pkg::S_SU_ISSUE;
          end
        end else begin
          dir_next = dir + 1'b1;
          state_next = gastar_pkg::S_NB;
        end
      end
      gastar_pkg::S_SU_ISSUE: begin
        if (heap_i == '0) begin
          heap_we = 1'b1;
          heap_wa = '0;
          heap_wd = push_key;
          dir_next = dir + 1'b1;
          state_next = gastar_pkg::S_NB;
        end else begin
          heap_ra = heap_p;
          state_next = gastar_pkg::S_SU_CMP;
        end
      end
      gastar_pkg::S_SU_CMP: begin
        heap_we = 1'b1;
        heap_wa = heap_i;
        if (heap_qa <= push_key) begin
          heap_wd = push_key;
          dir_next = dir + 1'b1;
          state_next = gastar_pkg::S_NB;
        end else begin
          heap_wd = heap_qa;
          heap_i_next = heap_p;
          state_next = gastar_pkg::S_SU_ISSUE;
        end
      end
      gastar_pkg::S_MARK_RD: begin
        grid_we = 1'b1;
        grid_wa = cell_of(walk_r, walk_c);
        grid_wd = gastar_pkg::CODE_PATH;
        info_ra = cell_of(walk_r, walk_c);
        walk_n_next = walk_n + 1'b1;
        state_next = gastar_pkg::S_MARK_GET;
      end
      gastar_pkg::S_MARK_GET: begin
        if (info_q.dir >= gastar_pkg::DIR_SELF || walk_n == WALK_W'(CELLS + 1)) begin
          state_next = gastar_pkg::S_FIN_SRC;
        end else begin
          case (info_q.dir)
            gastar_pkg::DIR_UP:    walk_r_next = walk_r + 1'b1;
            gastar_pkg::DIR_DOWN:  walk_r_next = walk_r - 1'b1;
            gastar_pkg::DIR_RIGHT: walk_c_next = walk_c - 1'b1;
            default:               walk_c_next = walk_c + 1'b1;
          endcase
          state_next = gastar_pkg::S_MARK_RD;
        end
      end
      gastar_pkg::S_FIN_SRC: begin
        grid_we = 1'b1;
        grid_wa = cell_of(src_r, src_c);
        grid_wd = gastar_pkg::CODE_START;
        state_next = gastar_pkg::S_FIN_DST;
      end
      gastar_pkg::S_FIN_DST: begin
        grid_we = 1'b1;
        grid_wa = cell_of(dst_r, dst_c);
        grid_wd = gastar_pkg::CODE_GOAL;
        res_valid_next = 1'b1;
        res_stat_next = gastar_pkg::STAT_OK;
        state_next = gastar_pkg::S_IDLE;
      end
      default: state_next = gastar_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gastar_pkg::S_CLEAR;
      res_valid <= 1'b0;
      sweep     <= '0;
      heap_cnt  <= '0;
      grid_rows <= 8'(DIM_LIM);
      grid_cols <= 8'(DIM_LIM);
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      sweep     <= sweep_next;
      heap_cnt  <= heap_cnt_next;
      if (cfg_wen) begin
        unique case (cfg_addr)
          gastar_pkg::REG_ROWS: grid_rows <= clamp_dim(cfg_wdata);
          gastar_pkg::REG_COLS: grid_cols <= clamp_dim(cfg_wdata);
          default: ;
        endcase
      end
    end
    res_code <= res_code_next;
    res_stat <= res_stat_next;
    src_r    <= src_r_next;
    src_c    <= src_c_next;
    dst_r    <= dst_r_next;
    dst_c    <= dst_c_next;
    cur_r    <= cur_r_next;
    cur_c    <= cur_c_next;
    nb_r     <= nb_r_next;
    nb_c     <= nb_c_next;
    walk_r   <= walk_r_next;
    walk_c   <= walk_c_next;
    walk_n   <= walk_n_next;
    g_cur    <= g_cur_next;
    ng       <= ng_next;
    nb_best  <= nb_best_next;
    dir      <= dir_next;
    heap_i   <= heap_i_next;
    last_key <= last_key_next;
    push_key <= push_key_next;
    sq_acc   <= sq_acc_next;
    sq_x     <= sq_x_next;
    sq_rem   <= sq_rem_next;
    sq_res   <= sq_res_next;
    sq_cnt   <= sq_cnt_next;
  end

  `GASTAR_ASSERT_IMP(a_no_accept_while_pending, s_tready, !m_tvalid)
  `GASTAR_ASSERT_NEXT(a_write_result_next, accept && s_tuser == gastar_pkg::OP_WRITE, m_tvalid)
  `GASTAR_ASSERT_IMP(a_sift_up_in_heap, state == gastar_pkg::S_SU_ISSUE, CNT_W'(heap_i) < heap_cnt)

endmodule

[sim/grid_astar_path_search_core_tb.sv]
// Self-checking testbench of the grid A* path search core with a built-in search predictor.
`timescale 1ns / 1ps

module grid_astar_path_search_core_tb;

  localparam int SIDE = 128;
  localparam int NCELL = SIDE * SIDE;
  localparam int HEAP_DEPTH = 16384;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct {
    logic [1:0] op;
    logic [6:0] row;
    logic [6:0] col;
    logic [1:0] code;
    logic [6:0] drow;
    logic [6:0] dcol;
  } cmd_t;

  typedef struct {
    logic [2:0] code;
    logic [1:0] status;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic cfg_wen = 1'b0;
  logic cfg_addr = 1'b0;
  logic [7:0] cfg_wdata = '0;

  grid_astar_path_search_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  cmd_t pending_cmds[$];
  reply_t expected_replies[$];
  int errors = 0;

  // Predicted state of the core.
  int used_rows = 128;
  int used_cols = 128;
  logic [2:0] cell_map[NCELL];
  int unsigned cost_map[NCELL];
  int unsigned steps_map[NCELL];
  logic [2:0] dir_map[NCELL];
  bit closed_map[NCELL];
  longint unsigned open_heap[HEAP_DEPTH];
  int unsigned open_n;
  int step_r[4] = '{-1, 1, 0, 0};
  int step_c[4] = '{0, 0, 1, -1};

  function automatic int clamp_dim(logic [7:0] v);
    int d;
    d = int'(v);
    if (d == 0) d = 1;
    if (d > 128) d = 128;
    return d;
  endfunction

  function automatic int unsigned sqrt_floor(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'h4000000000000000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return 32'(res);
  endfunction

  function automatic bit open_push(longint unsigned key);
    int unsigned i;
    int unsigned p;
    if (open_n >= HEAP_DEPTH) return 1'b0;
    i = open_n;
    open_n++;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (open_heap[p] <= key) break;
      open_heap[i] = open_heap[p];
      i = p;
    end
    open_heap[i] = key;
    return 1'b1;
  endfunction

  function automatic logic [1:0] astar_search(int sr, int sc, int dr, int dc);
    int unsigned src, cur, nidx, ng, j, l, s, y, x, idx;
    int ny, nx, r, c, k, d, n;
    longint unsigned key, last, nf, ddr, ddc;
    if (sr >= used_rows || sc >= used_cols || dr >= used_rows || dc >= used_cols)
      return gastar_pkg::STAT_REJECT;
    if (cell_map[sr * SIDE + sc] == gastar_pkg::CODE_BLOCKED ||
        cell_map[dr * SIDE + dc] == gastar_pkg::CODE_BLOCKED)
      return gastar_pkg::STAT_REJECT;
    if (sr == dr && sc == dc) return gastar_pkg::STAT_REJECT;
    for (int i = 0; i < NCELL; i++) begin
      cost_map[i] = gastar_pkg::COST_INF;
      closed_map[i] = 1'b0;
    end
    open_n = 0;
    src = sr * SIDE + sc;
    cost_map[src] = 0;
    steps_map[src] = 0;
    dir_map[src] = gastar_pkg::DIR_SELF;
    void'(open_push((longint'(sr) << 8) | longint'(sc)));
    while (open_n > 0) begin
      key = open_heap[0];
      open_n--;
      last = open_heap[open_n];
      j = 0;
      forever begin
        l = 2 * j + 1;
        if (l >= open_n) break;
        s = l;
        if (l + 1 < open_n && open_heap[l + 1] < open_heap[l]) s = l + 1;
        if (open_heap[s] >= last) break;
        open_heap[j] = open_heap[s];
        j = s;
      end
      if (open_n > 0) open_heap[j] = last;
      y = 32'((key >> 8) & 255);
      x = 32'(key & 255);
      cur = (y * SIDE + x) % NCELL;
      closed_map[cur] = 1'b1;
      for (k = 0; k < 4; k++) begin
        ny = int'(y) + step_r[k];
        nx = int'(x) + step_c[k];
        if (ny < 0 || nx < 0 || ny >= used_rows || nx >= used_cols) continue;
        nidx = ny * SIDE + nx;
        if (ny == dr && nx == dc) begin
          dir_map[nidx] = 3'(k);
          r = dr;
          c = dc;
          for (n = 0; n <= NCELL; n++) begin
            if (r < 0 || c < 0 || r >= SIDE || c >= SIDE) break;
            idx = r * SIDE + c;
            cell_map[idx] = gastar_pkg::CODE_PATH;
            d = int'(dir_map[idx]);
            if (d >= gastar_pkg::DIR_SELF) break;
            r = r - step_r[d];
            c = c - step_c[d];
          end
          cell_map[src] = gastar_pkg::CODE_START;
          cell_map[nidx] = gastar_pkg::CODE_GOAL;
          return gastar_pkg::STAT_OK;
        end
        if (closed_map[nidx] || cell_map[nidx] == gastar_pkg::CODE_BLOCKED) continue;
        ng = steps_map[cur] < gastar_pkg::STEPS_MAX ? steps_map[cur] + 1 : gastar_pkg::STEPS_MAX;
        ddr = longint'(ny > dr ? ny - dr : dr - ny);
        ddc = longint'(nx > dc ? nx - dc : dc - nx);
        nf = longint'(ng) * 1024 + sqrt_floor((ddr * ddr + ddc * ddc) << 20);
        if (nf > gastar_pkg::COST_MAXF) nf = gastar_pkg::COST_MAXF;
        if (cost_map[nidx] == gastar_pkg::COST_INF || cost_map[nidx] > nf) begin
          cost_map[nidx] = 32'(nf);
          steps_map[nidx] = ng;
          dir_map[nidx] = 3'(k);
          if (!open_push((nf << 16) | (longint'(ny) << 8) | longint'(nx)))
            return gastar_pkg::STAT_OVERFLOW;
        end
      end
    end
    return gastar_pkg::STAT_NOPATH;
  endfunction

  function automatic reply_t predict_reply(cmd_t t);
    reply_t o;
    o.code = '0;
    o.status = gastar_pkg::STAT_OK;
    case (t.op)
      gastar_pkg::OP_WRITE: begin
        if (t.row < used_rows && t.col < used_cols)
          cell_map[t.row * SIDE + t.col] = {1'b0, t.code};
        else o.status = gastar_pkg::STAT_REJECT;
      end
      gastar_pkg::OP_READ: begin
        if (t.row < used_rows && t.col < used_cols) o.code = cell_map[t.row * SIDE + t.col];
        else o.status = gastar_pkg::STAT_REJECT;
      end
      gastar_pkg::OP_RUN: o.status = astar_search(t.row, t.col, t.drow, t.dcol);
      default: ;
    endcase
    return o;
  endfunction

  task automatic report(string msg);
    if (errors < 100) $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    cmd_t t;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        t = pending_cmds.pop_front();
        s_tdata <= {2'b0, t.dcol, t.drow, t.code, t.col, t.row};
        s_tuser <= t.op;
        s_tvalid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Every accepted transaction is predicted in order of acceptance.
  always @(posedge clk) begin
    cmd_t t;
    reply_t e;
    if (!rst && s_tvalid && s_tready) begin
      t.row = s_tdata[6:0];
      t.col = s_tdata[13:7];
      t.code = s_tdata[15:14];
      t.drow = s_tdata[22:16];
      t.dcol = s_tdata[29:23];
      t.op = s_tuser;
      e = predict_reply(t);
      expected_replies = {expected_replies, e};
    end
  end

  // Receiver stall pattern: a duty cycle that is redrawn at random as the run goes on.
  int rx_cycle = 0;
  int rx_stall = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 512 == 0) rx_stall = $urandom_range(0, 8);
      m_tready <= (rx_cycle % 9) >= rx_stall;
    end
  end

  always @(posedge clk) begin
    reply_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_replies.size() == 0) begin
        report($sformatf("unexpected transaction %h", m_tdata));
      end else begin
        e = expected_replies.pop_front();
        if (m_tdata[2:0] !== e.code)
          report($sformatf("read_code %0d, expected %0d", m_tdata[2:0], e.code));
        if (m_tdata[4:3] !== e.status)
          report($sformatf("status %0d, expected %0d", m_tdata[4:3], e.status));
      end
    end
  end

  task automatic add_cmd(logic [1:0] op, int r, int c, int code, int dr, int dc);
    cmd_t t;
    t.op = op;
    t.row = 7'(r);
    t.col = 7'(c);
    t.code = 2'(code);
    t.drow = 7'(dr);
    t.dcol = 7'(dc);
    pending_cmds = {pending_cmds, t};
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() > 0 || s_tvalid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_dims(logic [7:0] rows, logic [7:0] cols);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= gastar_pkg::REG_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_addr <= gastar_pkg::REG_COLS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_wen <= 1'b0;
    used_rows = clamp_dim(rows);
    used_cols = clamp_dim(cols);
  endtask

  function automatic int pick_coord(int lim);
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, lim - 1);
  endfunction

  task automatic add_random(int n);
    int sel, code;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      code = ($urandom_range(0, 9) < 3) ? gastar_pkg::CODE_BLOCKED : $urandom_range(0, 3);
      if (sel < 3)
        add_cmd(OP_NONE, $urandom_range(0, 127), $urandom_range(0, 127), $urandom_range(0, 3),
                $urandom_range(0, 127), $urandom_range(0, 127));
      else if (sel < 6)
        add_cmd(gastar_pkg::OP_RUN, pick_coord(used_rows), pick_coord(used_cols),
                $urandom_range(0, 3), pick_coord(used_rows), pick_coord(used_cols));
      else if (sel < 55)
        add_cmd(gastar_pkg::OP_WRITE, pick_coord(used_rows), pick_coord(used_cols), code,
                $urandom_range(0, 127), $urandom_range(0, 127));
      else
        add_cmd(gastar_pkg::OP_READ, pick_coord(used_rows), pick_coord(used_cols),
                $urandom_range(0, 3), $urandom_range(0, 127), $urandom_range(0, 127));
    end
  endtask

  initial begin
    logic [7:0] dims[7][2];
    dims = '{'{8'd6, 8'd6}, '{8'd1, 8'd200}, '{8'd255, 8'd2},
             '{8'd0, 8'd0}, '{8'd10, 8'd13}, '{8'd16, 8'd16},
             '{8'd3, 8'd9}};
    for (int i = 0; i < NCELL; i++) cell_map[i] = gastar_pkg::CODE_FREE;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_dims(8'd128, 8'd128);

    // Full grid: field extremes, every opcode, short runs near the far corner.
    add_cmd(gastar_pkg::OP_WRITE, 0, 0, 3, 0, 0);
    add_cmd(gastar_pkg::OP_WRITE, 127, 127, 2, 127, 127);
    add_cmd(gastar_pkg::OP_READ, 0, 0, 0, 0, 0);
    add_cmd(gastar_pkg::OP_READ, 127, 127, 3, 127, 127);
    add_cmd(OP_NONE, 127, 127, 3, 127, 127);
    add_cmd(gastar_pkg::OP_RUN, 127, 127, 0, 127, 127);
    add_cmd(gastar_pkg::OP_WRITE, 126, 127, gastar_pkg::CODE_BLOCKED, 0, 0);
    add_cmd(gastar_pkg::OP_RUN, 127, 127, 0, 126, 127);
    add_cmd(gastar_pkg::OP_RUN, 126, 127, 0, 127, 124);
    add_cmd(gastar_pkg::OP_WRITE, 127, 126, gastar_pkg::CODE_BLOCKED, 0, 0);
    add_cmd(gastar_pkg::OP_WRITE, 126, 127, gastar_pkg::CODE_FREE, 0, 0);
    add_cmd(gastar_pkg::OP_RUN, 127, 127, 3, 125, 126);
    add_cmd(gastar_pkg::OP_READ, 126, 127, 0, 0, 0);
    add_cmd(gastar_pkg::OP_READ, 125, 127, 0, 0, 0);
    add_cmd(gastar_pkg::OP_READ, 125, 126, 0, 0, 0);
    wait_idle();

    // Tiny grid: out-of-range accesses, a walled-off destination.
    write_dims(8'd4, 8'd4);
    add_cmd(gastar_pkg::OP_WRITE, 4, 0, 1, 0, 0);
    add_cmd(gastar_pkg::OP_READ, 0, 4, 0, 0, 0);
    add_cmd(gastar_pkg::OP_RUN, 0, 0, 0, 0, 4);
    for (int r = 0; r < 4; r++) add_cmd(gastar_pkg::OP_WRITE, r, 1, gastar_pkg::CODE_BLOCKED, 0, 0);
    add_cmd(gastar_pkg::OP_RUN, 0, 0, 0, 3, 3);
    add_cmd(gastar_pkg::OP_WRITE, 2, 1, gastar_pkg::CODE_FREE, 0, 0);
    add_cmd(gastar_pkg::OP_RUN, 0, 0, 0, 3, 3);
    add_cmd(gastar_pkg::OP_READ, 2, 1, 0, 0, 0);
    wait_idle();

    for (int p = 0; p < 7; p++) begin
      write_dims(dims[p][0], dims[p][1]);
      add_random(p == 3 ? 150 : 260);
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
